FILE: src/wfq_pkg.sv
package wfq_pkg;

  localparam int unsigned TAG_W    = 48;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned OSUM_W   = 20;
  // running weight sum: enough for 256 flows of full weight
  localparam int unsigned SUM_W    = 24;
  // dividend is the length shifted into Q16.24 over a Q8.8 weight, giving a Q24.16 quotient
  localparam int unsigned DIVD_W   = LEN_W + 24;

  localparam logic [TAG_W-1:0]  TAG_MAX = {TAG_W{1'b1}};
  localparam logic [OSUM_W-1:0] OSUM_MAX = {OSUM_W{1'b1}};
  localparam logic [WGT_W-1:0]  WGT_RST = 16'd256;

  typedef enum logic [1:0] {
    REQ_ARRIVE = 2'd0,
    REQ_SERVE  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } cmd_e;

  // record handed from cell to cell during a scan
  typedef struct packed {
    logic             hit;
    logic             hit_full;
    logic [WGT_W-1:0] hit_weight;
    logic [TAG_W-1:0] hit_last;
    logic             free_hit;
    logic             best_vld;
    logic [TAG_W-1:0] best_tag;
    logic [ID_W-1:0]  best_id;
    logic [SUM_W-1:0] sum;
  } scan_t;

  // update broadcast to the row of cells
  typedef struct packed {
    cmd_e              op;
    logic              create;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [2*PORT_W-1:0] ports;
    logic [WGT_W-1:0]  weight;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
  } cmd_t;

  function automatic logic [WGT_W-1:0] nz_weight(input logic [WGT_W-1:0] w);
    nz_weight = (w == '0) ? {{(WGT_W-1){1'b0}}, 1'b1} : w;
  endfunction

endpackage

FILE: src/wfq_req_if.sv
interface wfq_req_if import wfq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [ADDR_W-1:0]  src_addr;
  logic [PORT_W-1:0]  src_port;
  logic [ADDR_W-1:0]  dst_addr;
  logic [PORT_W-1:0]  dst_port;
  logic [LEN_W-1:0]   pkt_length;
  logic               weight_given;
  logic [WGT_W-1:0]   new_weight;
  logic [TAG_W-1:0]   round_now;
  logic [ID_W-1:0]    packet_id;

  modport source (output valid, req_type, src_addr, src_port, dst_addr, dst_port,
                  pkt_length, weight_given, new_weight, round_now, packet_id,
                  input ready);
  modport sink (input valid, req_type, src_addr, src_port, dst_addr, dst_port,
                pkt_length, weight_given, new_weight, round_now, packet_id,
                output ready);
endinterface

FILE: src/wfq_rsp_if.sv
interface wfq_rsp_if import wfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FIDX_W-1:0] flow_index;
  logic [ID_W-1:0]   served_id;
  logic [TAG_W-1:0]  finish_tag;
  logic [OSUM_W-1:0] weight_sum;

  modport source (output valid, status, flow_index, served_id, finish_tag,
                  weight_sum, input ready);
  modport sink (input valid, status, flow_index, served_id, finish_tag,
                weight_sum, output ready);
endinterface

FILE: src/wfq_div.sv
module wfq_div import wfq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [WGT_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);
  localparam int unsigned CW = $clog2(DIVD_W + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [WGT_W-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [WGT_W:0]    rem_sh;

  // one quotient bit a cycle, restoring
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[DIVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = WGT_W'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WGT_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

FILE: src/wfq_cell.sv
module wfq_cell import wfq_pkg::*; #(
  parameter int unsigned FLOWS      = 16,
  parameter int unsigned FLOW_DEPTH = 16,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scan_t                      scan_i,
  input  logic [$clog2(FLOWS)-1:0]   hit_idx_i,
  input  logic [$clog2(FLOWS)-1:0]   free_idx_i,
  input  logic [$clog2(FLOWS)-1:0]   best_idx_i,
  output scan_t                      scan_o,
  output logic [$clog2(FLOWS)-1:0]   hit_idx_o,
  output logic [$clog2(FLOWS)-1:0]   free_idx_o,
  output logic [$clog2(FLOWS)-1:0]   best_idx_o,
  input  logic [ADDR_W-1:0]          src_addr_i,
  input  logic [ADDR_W-1:0]          dst_addr_i,
  input  logic [2*PORT_W-1:0]        ports_i,
  input  logic [TAG_W-1:0]           round_i,
  input  cmd_t                       cmd_i,
  input  logic [$clog2(FLOWS)-1:0]   cmd_idx_i
);
  localparam int unsigned IW = $clog2(FLOWS);
  localparam int unsigned DW = $clog2(FLOW_DEPTH);
  localparam int unsigned PW = $clog2(FLOW_DEPTH + 1);
  localparam logic [IW-1:0] ME = IW'(CELL_IDX);

  logic                valid_q;
  logic [ADDR_W-1:0]   src_q, dst_q;
  logic [2*PORT_W-1:0] ports_q;
  logic [WGT_W-1:0]    weight_q;
  logic [TAG_W-1:0]    last_q;
  logic [PW-1:0]       pend_q;
  logic [DW-1:0]       head_q, tail_q, wr_ptr;
  logic [TAG_W-1:0]    mem_tag [FLOW_DEPTH];
  logic [ID_W-1:0]     mem_id  [FLOW_DEPTH];
  logic [TAG_W-1:0]    head_tag_q;
  logic [ID_W-1:0]     head_id_q;

  scan_t         scan_d;
  logic [IW-1:0] hit_idx_d, free_idx_d, best_idx_d;
  logic          sel, push, pop;

  function automatic logic [DW-1:0] ptr_next(input logic [DW-1:0] p);
    ptr_next = (p == DW'(FLOW_DEPTH - 1)) ? '0 : DW'(p + 1'b1);
  endfunction

  always_comb begin
    scan_d     = scan_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    best_idx_d = best_idx_i;
    if (valid_q && !scan_i.hit && src_q == src_addr_i && dst_q == dst_addr_i &&
        ports_q == ports_i) begin
      scan_d.hit        = 1'b1;
      scan_d.hit_full   = (pend_q == PW'(FLOW_DEPTH));
      scan_d.hit_weight = weight_q;
      scan_d.hit_last   = last_q;
      hit_idx_d         = ME;
    end
    if (!valid_q && !scan_i.free_hit) begin
      scan_d.free_hit = 1'b1;
      free_idx_d      = ME;
    end
    // strict compare keeps the lower index on a tie
    if (valid_q && pend_q != '0 && (!scan_i.best_vld || head_tag_q < scan_i.best_tag)) begin
      scan_d.best_vld = 1'b1;
      scan_d.best_tag = head_tag_q;
      scan_d.best_id  = head_id_q;
      best_idx_d      = ME;
    end
    if (valid_q && last_q > round_i) begin
      scan_d.sum = scan_i.sum + SUM_W'(weight_q);
    end
  end

  always_ff @(posedge clk_i) begin
    scan_o     <= scan_d;
    hit_idx_o  <= hit_idx_d;
    free_idx_o <= free_idx_d;
    best_idx_o <= best_idx_d;
  end

  assign sel    = (cmd_idx_i == ME);
  assign push   = sel && (cmd_i.op == CMD_PUSH);
  assign pop    = sel && (cmd_i.op == CMD_POP);
  assign wr_ptr = cmd_i.create ? '0 : tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else if (push) begin
      valid_q <= 1'b1;
      if (cmd_i.create) begin
        pend_q <= PW'(1);
        head_q <= '0;
        tail_q <= ptr_next('0);
      end else begin
        pend_q <= pend_q + 1'b1;
        tail_q <= ptr_next(tail_q);
      end
    end else if (pop) begin
      pend_q <= pend_q - 1'b1;
      head_q <= ptr_next(head_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (cmd_i.create) begin
        src_q   <= cmd_i.src_addr;
        dst_q   <= cmd_i.dst_addr;
        ports_q <= cmd_i.ports;
      end
      weight_q        <= cmd_i.weight;
      last_q          <= cmd_i.tag;
      mem_tag[wr_ptr] <= cmd_i.tag;
      mem_id[wr_ptr]  <= cmd_i.id;
    end
    head_tag_q <= mem_tag[head_q];
    head_id_q  <= mem_id[head_q];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pend_q != '0)
    else $error("pop from an empty flow queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !cmd_i.create |-> valid_q && pend_q != PW'(FLOW_DEPTH))
    else $error("push to a missing or full flow queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(FLOW_DEPTH))
    else $error("flow occupancy beyond depth");
endmodule

FILE: src/wfq_tag_and_select.sv
// Sequence: an arrival scans the row of flow cells, runs the 40-step bit-serial divide and
//   commits the push; a serve scans and commits the pop; a query scans; an unused request
//   type skips the scan. A full flow or table, or an empty serve, skips divide and commit.
//   Every result then loads the output register, which holds the result stage until drained.
// Handshake: one item at a time; the next item is taken once the previous result is
//   in the output register.
// Reset: asynchronous, active low; empties the flow table and restores the default weight.
module wfq_tag_and_select import wfq_pkg::*; #(
  parameter int unsigned FLOWS      = 16,
  parameter int unsigned FLOW_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WGT_W-1:0]  cfg_wdata_i,
  wfq_req_if.sink           req_i,
  wfq_rsp_if.source         rsp_o
);
  localparam int unsigned IW = $clog2(FLOWS);
  localparam int unsigned CW = $clog2(FLOWS + 2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DIV    = 5'b00100,
    S_COMMIT = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [WGT_W-1:0] dflt_q;

  // held request
  logic [1:0]          type_q;
  logic [ADDR_W-1:0]   src_q, dst_q;
  logic [2*PORT_W-1:0] ports_q;
  logic [LEN_W-1:0]    len_q;
  logic                wgiven_q;
  logic [WGT_W-1:0]    nweight_q;
  logic [TAG_W-1:0]    round_q;
  logic [ID_W-1:0]     pid_q;

  // commit and result staging
  cmd_e              op_q;
  logic              create_q;
  logic [IW-1:0]     tgt_q;
  logic [WGT_W-1:0]  weight_q;
  logic [TAG_W-1:0]  base_q;
  logic [1:0]        res_st_q;
  logic [ID_W-1:0]   res_id_q;
  logic [TAG_W-1:0]  res_tag_q;
  logic [OSUM_W-1:0] res_sum_q;

  // output register
  logic              ovalid_q;
  logic [1:0]        ost_q;
  logic [FIDX_W-1:0] oidx_q;
  logic [ID_W-1:0]   oid_q;
  logic [TAG_W-1:0]  otag_q;
  logic [OSUM_W-1:0] osum_q;

  scan_t         chain    [FLOWS+1];
  logic [IW-1:0] hit_idx  [FLOWS+1];
  logic [IW-1:0] free_idx [FLOWS+1];
  logic [IW-1:0] best_idx [FLOWS+1];
  cmd_t          cmd;
  scan_t         res;

  logic              accept, div_start, div_busy, div_done;
  logic [DIVD_W-1:0] quot;
  logic [TAG_W:0]    tag_sum;
  logic [TAG_W-1:0]  new_tag;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // feed an empty record into the head of the row every cycle
  assign chain[0]    = '0;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign best_idx[0] = '0;
  assign res         = chain[FLOWS];

  assign cmd.op       = (state_q == S_COMMIT) ? op_q : CMD_NONE;
  assign cmd.create   = create_q;
  assign cmd.src_addr = src_q;
  assign cmd.dst_addr = dst_q;
  assign cmd.ports    = ports_q;
  assign cmd.weight   = weight_q;
  assign cmd.tag      = res_tag_q;
  assign cmd.id       = pid_q;

  for (genvar g = 0; g < FLOWS; g++) begin : g_cell
    wfq_cell #(
      .FLOWS      (FLOWS),
      .FLOW_DEPTH (FLOW_DEPTH),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .scan_i     (chain[g]),
      .hit_idx_i  (hit_idx[g]),
      .free_idx_i (free_idx[g]),
      .best_idx_i (best_idx[g]),
      .scan_o     (chain[g+1]),
      .hit_idx_o  (hit_idx[g+1]),
      .free_idx_o (free_idx[g+1]),
      .best_idx_o (best_idx[g+1]),
      .src_addr_i (src_q),
      .dst_addr_i (dst_q),
      .ports_i    (ports_q),
      .round_i    (round_q),
      .cmd_i      (cmd),
      .cmd_idx_i  (tgt_q)
    );
  end

  wfq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({len_q, 24'd0}),
    .divisor_i  (weight_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // saturate the finish tag at the top of Q32.16
  assign tag_sum = {1'b0, base_q} + (TAG_W+1)'(quot);
  assign new_tag = tag_sum[TAG_W] ? TAG_MAX : tag_sum[TAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= WGT_RST;
    end else if (cfg_we_i) begin
      dflt_q <= cfg_wdata_i;
    end
  end

  // start the divide the cycle after the scan settles an arrival
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state_q == S_SCAN && cnt_q == CW'(FLOWS + 1) && type_q == REQ_ARRIVE &&
          (res.hit ? !res.hit_full : res.free_hit)) begin
        div_start <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      op_q     <= CMD_NONE;
    end else begin
      // drop the output item once taken, unless a new one is loaded now
      if (ovalid_q && rsp_o.ready && state_q != S_OUT) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q     <= '0;
            op_q      <= CMD_NONE;
            res_st_q  <= ST_OK;
            tgt_q     <= '0;
            res_id_q  <= '0;
            res_tag_q <= '0;
            res_sum_q <= '0;
            state_q   <= (req_i.req_type == REQ_NONE) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(FLOWS + 1)) begin
            case (type_q)
              REQ_SERVE: begin
                if (res.best_vld) begin
                  op_q      <= CMD_POP;
                  create_q  <= 1'b0;
                  tgt_q     <= best_idx[FLOWS];
                  res_id_q  <= res.best_id;
                  res_tag_q <= res.best_tag;
                  state_q   <= S_COMMIT;
                end else begin
                  res_st_q <= ST_EMPTY;
                  state_q  <= S_OUT;
                end
              end
              REQ_QUERY: begin
                res_sum_q <= (res.sum > SUM_W'(OSUM_MAX)) ? OSUM_MAX
                                                          : res.sum[OSUM_W-1:0];
                state_q   <= S_OUT;
              end
              default: begin
                // arrival: find the flow, or open one in the lowest free slot
                res_id_q <= pid_q;
                if (res.hit) begin
                  tgt_q <= hit_idx[FLOWS];
                  if (res.hit_full) begin
                    res_st_q <= ST_FULL;
                    state_q  <= S_OUT;
                  end else begin
                    create_q <= 1'b0;
                    weight_q <= wgiven_q ? nz_weight(nweight_q) : res.hit_weight;
                    base_q   <= (res.hit_last >= round_q) ? res.hit_last : round_q;
                    state_q  <= S_DIV;
                  end
                end else if (res.free_hit) begin
                  tgt_q    <= free_idx[FLOWS];
                  create_q <= 1'b1;
                  weight_q <= nz_weight(wgiven_q ? nweight_q : dflt_q);
                  base_q   <= round_q;
                  state_q  <= S_DIV;
                end else begin
                  res_st_q <= ST_FULL;
                  state_q  <= S_OUT;
                end
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            op_q      <= CMD_PUSH;
            res_tag_q <= new_tag;
            state_q   <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to drain
          if (!ovalid_q || rsp_o.ready) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // hold the request and load the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q    <= req_i.req_type;
      src_q     <= req_i.src_addr;
      dst_q     <= req_i.dst_addr;
      ports_q   <= {req_i.src_port, req_i.dst_port};
      len_q     <= req_i.pkt_length;
      wgiven_q  <= req_i.weight_given;
      nweight_q <= req_i.new_weight;
      round_q   <= req_i.round_now;
      pid_q     <= req_i.packet_id;
    end
    if (state_q == S_OUT && (!ovalid_q || rsp_o.ready)) begin
      ost_q  <= res_st_q;
      oidx_q <= FIDX_W'(tgt_q);
      oid_q  <= res_id_q;
      otag_q <= res_tag_q;
      osum_q <= res_sum_q;
    end
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.status     = ost_q;
  assign rsp_o.flow_index = oidx_q;
  assign rsp_o.served_id  = oid_q;
  assign rsp_o.finish_tag = otag_q;
  assign rsp_o.weight_sum = osum_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> state_q != S_IDLE)
    else $error("accepted item dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider running outside the divide phase");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == CMD_POP |-> res_st_q == ST_OK)
    else $error("pop committed with an error status");
endmodule
